[src/epg_pkg.sv]
// ----------------------------------------------------------------------------
// epg_pkg - shared types and constants for the gap material block
// Op codes, register indexes, unit request/response words, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package epg_pkg;

  localparam int STRAIN_FRAC_BITS = 24;
  localparam int STRESS_FRAC_BITS = 8;
  localparam int RATIO_FRAC_BITS  = 16;

  localparam int DIV_Q_BITS = 33;
  localparam int S2S_STEPS  = 32;
  localparam int RL_STEPS   = 33;
  localparam int MUL_STEPS  = 31;

  localparam logic [33:0] Q_CLAMP   = 34'(1) << 33;
  localparam logic [16:0] RATIO_ONE = 17'(1) << RATIO_FRAC_BITS;

  localparam logic [30:0] MOD_RESET   = 31'd51200000;
  localparam logic [30:0] FY_RESET    = 31'd64000;
  localparam logic [30:0] GAP_RESET   = 31'd0;
  localparam logic [15:0] RATIO_RESET = 16'd0;
  localparam logic        TENS_RESET  = 1'b1;

  // window after reset: gap is zero and the gap acts in tension
  localparam logic signed [31:0] LOWER_RESET   = 32'(GAP_RESET);
  localparam logic signed [31:0] UPPER_RESET   =
    32'((64'(FY_RESET) << STRAIN_FRAC_BITS) / 64'(MOD_RESET));
  localparam logic signed [31:0] TANGENT_RESET = 32'(MOD_RESET);

  localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] SAT_MIN = 36'shF_8000_0000;

  typedef enum logic [1:0] {
    OP_TRIAL,
    OP_COMMIT,
    OP_REVERT,
    OP_INIT
  } epg_op_t;

  typedef enum logic [2:0] {
    CFG_MODULUS,
    CFG_YIELD,
    CFG_GAP,
    CFG_RATIO,
    CFG_MODE
  } epg_cfg_idx_t;

  typedef struct packed {
    logic               start;
    logic               reload;
    logic signed [33:0] x;
    logic [30:0]        divisor;
  } epg_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [34:0] q;
  } epg_div_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [33:0] d;
    logic [30:0]        b;
  } epg_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] p;
  } epg_mul_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/epg_in_if.sv]
// ----------------------------------------------------------------------------
// epg_in_if - input channel
// valid/ready handshake carrying one op word.
// ----------------------------------------------------------------------------
`default_nettype none

interface epg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] strain_in;

  modport source (output valid, output op, output strain_in, input ready);
  modport sink   (input valid, input op, input strain_in, output ready);
endinterface

`default_nettype wire

[src/epg_out_if.sv]
// ----------------------------------------------------------------------------
// epg_out_if - result channel
// valid/ready handshake carrying stress and tangent.
// ----------------------------------------------------------------------------
`default_nettype none

interface epg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] stress_out;
  logic signed [31:0] tangent_out;

  modport source (output valid, output stress_out, output tangent_out, input ready);
  modport sink   (input valid, input stress_out, input tangent_out, output ready);
endinterface

`default_nettype wire

[src/elastic_plastic_gap_material.sv]
// ----------------------------------------------------------------------------
// elastic_plastic_gap_material - 1-D elastic-plastic gap material, fixed point
// Trial update, commit, revert and reinitialise on a serial divide/multiply
// datapath; one stress/tangent word per op word.
// ----------------------------------------------------------------------------
// Each op word gives exactly one result word with the stress and tangent
// after the step. Strain is Q8.24, stress and modulus Q24.8, ratio Q0.16.
// Work per op is set by the bit-serial divider and multiplier. Revert and
// slack trial use neither, elastic trial one multiply, plastic trial a
// divide then a multiply, commit after plastic flow and reinitialise one
// divide, commit after reloading a strain divide then a reload divide.
// A new op word is taken once the previous one has reached the output
// register, even while that result still waits to be read. Register
// writes do not move the yield window; only reset, reinitialise and
// commit change it.
`default_nettype none

module elastic_plastic_gap_material (
  input  logic             clk,
  input  logic             rst_n,
  epg_in_if.sink           in_chan,
  epg_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [30:0]      cfg_wdata
);
  import epg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_DIV1, S_AFTER1, S_DIV2, S_AFTER2, S_MUL, S_DONE
  } state_t;

  // configuration
  logic [30:0] mod_r;
  logic [30:0] fy_r;
  logic [30:0] gap_r;
  logic [15:0] ratio_r;
  logic        tens_r;
  logic [30:0] re_r;
  logic [30:0] rg_r;

  // material state
  logic signed [31:0] trial_r;
  logic signed [31:0] committed_r;
  logic signed [31:0] stress_r;
  logic signed [31:0] tangent_r;
  logic signed [31:0] lower_r;
  logic signed [31:0] upper_r;

  state_t             state_r;
  epg_op_t            op_r;
  logic               plastic_r;
  logic signed [31:0] q1_r;
  logic signed [34:0] q2_r;
  logic               out_valid_r;
  logic signed [31:0] out_stress_r;
  logic signed [31:0] out_tangent_r;

  epg_div_req_t div_req_r;
  epg_div_rsp_t div_rsp;
  epg_mul_req_t mul_req_r;
  epg_mul_rsp_t mul_rsp;

  logic [46:0]        re_prod;
  logic [46:0]        rg_prod;
  logic [30:0]        mod_nz;
  logic [16:0]        den;
  logic signed [31:0] sg;
  logic signed [31:0] sfy;
  logic signed [31:0] srg;
  logic               above;
  logic               below;
  logic               reloaded;
  logic signed [33:0] d_el;
  logic signed [33:0] d_pl;
  logic signed [33:0] num_rl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r   <= MOD_RESET;
      fy_r    <= FY_RESET;
      gap_r   <= GAP_RESET;
      ratio_r <= RATIO_RESET;
      tens_r  <= TENS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS: mod_r   <= cfg_wdata;
        CFG_YIELD:   fy_r    <= cfg_wdata;
        CFG_GAP:     gap_r   <= cfg_wdata;
        CFG_RATIO:   ratio_r <= cfg_wdata[15:0];
        CFG_MODE:    tens_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    re_prod = 47'(ratio_r) * 47'(mod_r);
    rg_prod = 47'(gap_r) * 47'(ratio_r);
  end

  // ratio products, refreshed every cycle from the registers
  always_ff @(posedge clk) begin
    re_r <= re_prod[30+RATIO_FRAC_BITS:RATIO_FRAC_BITS];
    rg_r <= rg_prod[30+RATIO_FRAC_BITS:RATIO_FRAC_BITS];
  end

  always_comb begin
    mod_nz   = (mod_r == '0) ? 31'd1 : mod_r;
    den      = 17'(RATIO_ONE - {1'b0, ratio_r});
    sg       = tens_r ? $signed({1'b0, gap_r}) : -$signed({1'b0, gap_r});
    sfy      = tens_r ? $signed({1'b0, fy_r}) : -$signed({1'b0, fy_r});
    srg      = tens_r ? $signed({1'b0, rg_r}) : -$signed({1'b0, rg_r});
    above    = tens_r ? (trial_r > upper_r) : (trial_r < upper_r);
    below    = tens_r ? (trial_r < lower_r) : (trial_r > lower_r);
    reloaded = tens_r ? ((trial_r < lower_r) && (sg < trial_r))
                      : ((lower_r < trial_r) && (trial_r < sg));
    d_el     = 34'(trial_r) - 34'(lower_r);
    d_pl     = 34'(trial_r) - 34'(sg) - 34'(q1_r);
    num_rl   = 34'(trial_r) - 34'(srg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TRIAL;
      plastic_r   <= 1'b0;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
      mul_req_r   <= '0;
      trial_r     <= '0;
      committed_r <= '0;
      stress_r    <= '0;
      tangent_r   <= TANGENT_RESET;
      lower_r     <= LOWER_RESET;
      upper_r     <= UPPER_RESET;
    end else begin
      div_req_r.start <= 1'b0;
      mul_req_r.start <= 1'b0;
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r <= epg_op_t'(in_chan.op);
            if (epg_op_t'(in_chan.op) == OP_TRIAL) begin
              trial_r <= in_chan.strain_in;
            end
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (op_r)
            OP_TRIAL: begin
              plastic_r <= above;
              if (above) begin
                div_req_r <= '{start: 1'b1, reload: 1'b0, x: 34'(sfy), divisor: mod_nz};
                state_r   <= S_DIV1;
              end else if (below) begin
                stress_r  <= '0;
                tangent_r <= '0;
                state_r   <= S_DONE;
              end else begin
                mul_req_r <= '{start: 1'b1, d: d_el, b: mod_r};
                tangent_r <= $signed({1'b0, mod_r});
                state_r   <= S_MUL;
              end
            end
            OP_COMMIT: begin
              committed_r <= trial_r;
              plastic_r   <= above;
              if (above) begin
                upper_r   <= trial_r;
                div_req_r <= '{start: 1'b1, reload: 1'b0, x: 34'(stress_r),
                               divisor: mod_nz};
                state_r   <= S_DIV1;
              end else if (reloaded) begin
                div_req_r <= '{start: 1'b1, reload: 1'b0, x: 34'(sfy), divisor: mod_nz};
                state_r   <= S_DIV1;
              end else begin
                state_r <= S_DONE;
              end
            end
            OP_REVERT: begin
              trial_r <= committed_r;
              state_r <= S_DONE;
            end
            OP_INIT: begin
              lower_r     <= sg;
              committed_r <= '0;
              trial_r     <= '0;
              stress_r    <= '0;
              tangent_r   <= (gap_r == '0) ? $signed({1'b0, mod_r}) : 32'sd0;
              div_req_r   <= '{start: 1'b1, reload: 1'b0, x: 34'(sfy), divisor: mod_nz};
              state_r     <= S_DIV1;
            end
          endcase
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            q1_r    <= sat32(36'($signed(div_rsp.q)));
            state_r <= S_AFTER1;
          end
        end
        S_AFTER1: begin
          unique case (op_r)
            OP_TRIAL: begin
              mul_req_r <= '{start: 1'b1, d: d_pl, b: re_r};
              tangent_r <= $signed({1'b0, re_r});
              state_r   <= S_MUL;
            end
            OP_COMMIT: begin
              if (plastic_r) begin
                lower_r <= sat32(36'(trial_r) - 36'(q1_r));
                state_r <= S_DONE;
              end else begin
                div_req_r <= '{start: 1'b1, reload: 1'b1, x: num_rl, divisor: 31'(den)};
                state_r   <= S_DIV2;
              end
            end
            OP_INIT: begin
              upper_r <= sat32(36'(sg) + 36'(q1_r));
              state_r <= S_DONE;
            end
            OP_REVERT: state_r <= S_DONE;
          endcase
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            q2_r    <= div_rsp.q;
            state_r <= S_AFTER2;
          end
        end
        S_AFTER2: begin
          upper_r <= sat32(36'(q1_r) + 36'(q2_r));
          lower_r <= trial_r;
          state_r <= S_DONE;
        end
        S_MUL: begin
          if (mul_rsp.done) begin
            stress_r <= plastic_r ? sat32(36'(sfy) + 36'($signed(mul_rsp.p))) : mul_rsp.p;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r   <= 1'b1;
            out_stress_r  <= stress_r;
            out_tangent_r <= tangent_r;
            state_r       <= S_IDLE;
          end
        end
      endcase
    end
  end

  epg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  epg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req_r),
    .rsp   (mul_rsp)
  );

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.stress_out  = out_stress_r;
  assign out_chan.tangent_out = out_tangent_r;

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished with no op waiting on it");

  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_MUL))
    else $error("multiplier finished with no op waiting on it");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word loaded outside the done step");

endmodule

`default_nettype wire

[src/epg_div.sv]
// ----------------------------------------------------------------------------
// epg_div - bit-serial restoring divider
// Signed dividend scaled by 2^24 (strain mode) or 2^16 (reload mode),
// one quotient bit per cycle, truncation toward zero, overflow clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module epg_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  epg_pkg::epg_div_req_t req,
  output epg_pkg::epg_div_rsp_t rsp
);
  import epg_pkg::*;

  localparam int SW = STRAIN_FRAC_BITS;
  localparam int RW = RATIO_FRAC_BITS;

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_FIN} div_state_t;

  div_state_t            state_r;
  logic                  neg_r;
  logic                  ovf_r;
  logic [30:0]           rem_r;
  logic [30:0]           dvs_r;
  logic [DIV_Q_BITS-1:0] bits_r;
  logic [DIV_Q_BITS-1:0] quo_r;
  logic [5:0]            cnt_r;
  epg_div_rsp_t          rsp_r;

  logic [33:0]    mag;
  logic [31+SW:0] dvd_s;
  logic [33+RW:0] dvd_l;
  logic [31:0]    part;
  logic           ge;
  logic [33:0]    mag_c;

  always_comb begin
    mag   = req.x[33] ? 34'(~req.x + 34'd1) : 34'(req.x);
    dvd_s = {mag[31:0], {SW{1'b0}}};
    dvd_l = {mag, {RW{1'b0}}};
    part  = {rem_r, bits_r[DIV_Q_BITS-1]};
    ge    = part >= {1'b0, dvs_r};
    mag_c = ovf_r ? Q_CLAMP : {1'b0, quo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      rsp_r   <= '0;
    end else begin
      rsp_r.done <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (req.start) begin
            neg_r <= req.x[33];
            dvs_r <= req.divisor;
            quo_r <= '0;
            if (req.reload) begin
              rem_r  <= 31'(dvd_l[33+RW:33]);
              bits_r <= dvd_l[32:0];
              cnt_r  <= 6'(RL_STEPS);
            end else begin
              rem_r  <= 31'(dvd_s[31+SW:32]);
              bits_r <= {dvd_s[31:0], 1'b0};
              cnt_r  <= 6'(S2S_STEPS);
            end
            state_r <= D_CHECK;
          end
        end
        D_CHECK: begin
          ovf_r   <= rem_r >= dvs_r;
          state_r <= D_RUN;
        end
        D_RUN: begin
          rem_r  <= ge ? 31'(part - {1'b0, dvs_r}) : part[30:0];
          bits_r <= {bits_r[DIV_Q_BITS-2:0], 1'b0};
          quo_r  <= {quo_r[DIV_Q_BITS-2:0], ge};
          cnt_r  <= 6'(cnt_r - 6'd1);
          if (cnt_r == 6'd1) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          rsp_r.done <= 1'b1;
          rsp_r.q    <= neg_r ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
          state_r    <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

[src/epg_mul.sv]
// ----------------------------------------------------------------------------
// epg_mul - bit-serial shift-add multiplier
// Signed strain times unsigned stiffness, one multiplier bit per cycle,
// scaled down by 2^24 with magnitude truncation and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module epg_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  epg_pkg::epg_mul_req_t req,
  output epg_pkg::epg_mul_rsp_t rsp
);
  import epg_pkg::*;

  localparam int SW = STRAIN_FRAC_BITS;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mul_state_t;

  mul_state_t   state_r;
  logic         neg_r;
  logic [33:0]  m_r;
  logic [33:0]  acc_r;
  logic [30:0]  b_r;
  logic [4:0]   cnt_r;
  epg_mul_rsp_t rsp_r;

  logic [33:0] mag;
  logic [34:0] sum;
  logic [64:0] prod;
  logic [31:0] mag_raw;
  logic        big;
  logic [31:0] mag32;

  always_comb begin
    mag     = req.d[33] ? 34'(~req.d + 34'd1) : 34'(req.d);
    sum     = {1'b0, acc_r} + (b_r[0] ? {1'b0, m_r} : 35'd0);
    prod    = {acc_r, b_r};
    mag_raw = prod[31+SW:SW];
    big     = (|prod[64:32+SW]) || (mag_raw[31] && (|mag_raw[30:0]));
    mag32   = big ? 32'h8000_0000 : mag_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      rsp_r   <= '0;
    end else begin
      rsp_r.done <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (req.start) begin
            neg_r   <= req.d[33];
            m_r     <= mag;
            acc_r   <= '0;
            b_r     <= req.b;
            cnt_r   <= 5'(MUL_STEPS);
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= sum[34:1];
          b_r   <= {sum[0], b_r[30:1]};
          cnt_r <= 5'(cnt_r - 5'd1);
          if (cnt_r == 5'd1) begin
            state_r <= M_FIN;
          end
        end
        M_FIN: begin
          rsp_r.done <= 1'b1;
          if (neg_r) begin
            rsp_r.p <= -$signed(mag32);
          end else begin
            rsp_r.p <= mag32[31] ? 32'sh7FFF_FFFF : $signed(mag32);
          end
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

[test/elastic_plastic_gap_material_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_plastic_gap_material_test - testbench for the gap material block
// Walks a short table of op words and register writes, a few results typed
// in, then runs phases of random register settings with commit/trial
// sequences aimed at the yield window. Every result word is checked against
// a typed result or a local predictor; both channels idle in random bursts.
// ----------------------------------------------------------------------------

module elastic_plastic_gap_material_test;
  import epg_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 110;
  localparam int HOLD_PHASE      = 3;

  localparam logic [2:0] CFG_SPARE      = 3'd5;
  localparam logic [2:0] CFG_SPARE_LAST = 3'd7;

  localparam longint I32_HI = 64'sd2147483647;
  localparam longint I32_LO = -64'sd2147483647 - 64'sd1;

  typedef struct packed {
    logic signed [31:0] stress;
    logic signed [31:0] tangent;
  } gap_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    epg_op_t            op;
    logic [2:0]         reg_index;
    logic signed [31:0] value;
    logic               known;
    gap_result_t        result;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_wdata;

  epg_in_if  in_chan ();
  epg_out_if out_chan ();

  elastic_plastic_gap_material uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // material registers and state as the predictor sees them
  logic [30:0]        mat_modulus;
  logic [30:0]        mat_yield;
  logic [30:0]        mat_gap;
  logic [15:0]        mat_ratio;
  logic               mat_tension;
  logic signed [31:0] strain_trial;
  logic signed [31:0] strain_committed;
  logic signed [31:0] cur_stress;
  logic signed [31:0] cur_tangent;
  logic signed [31:0] win_lower;
  logic signed [31:0] win_upper;

  gap_result_t expected_results[$];
  logic        use_typed;
  gap_result_t typed_result;
  logic        idle_on;
  logic        hold_req;
  int          failures;

  function automatic longint clamp32(longint v);
    if (v > I32_HI) return I32_HI;
    if (v < I32_LO) return I32_LO;
    return v;
  endfunction

  function automatic longint modulus_div();
    return (mat_modulus == 0) ? 64'sd1 : longint'(mat_modulus);
  endfunction

  function automatic longint to_strain(longint stress);
    return clamp32((stress * (64'sd1 <<< STRAIN_FRAC_BITS)) / modulus_div());
  endfunction

  function automatic longint signed_yield();
    return mat_tension ? longint'(mat_yield) : -longint'(mat_yield);
  endfunction

  function automatic longint signed_gap();
    return mat_tension ? longint'(mat_gap) : -longint'(mat_gap);
  endfunction

  // strain times stiffness, truncated on the magnitude, saturated
  function automatic longint scale_mul(longint a, logic [63:0] b);
    logic [63:0] mag_in;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] mag;
    logic        neg;
    neg = a < 0;
    mag_in = neg ? -a : a;
    hi = (mag_in >> 32) * b;
    lo = (mag_in & 64'hFFFF_FFFF) * b;
    if (hi >= (64'd1 << (STRAIN_FRAC_BITS - 1))) begin
      mag = 64'd1 << 31;
    end else begin
      mag = (hi << (32 - STRAIN_FRAC_BITS)) + (lo >> STRAIN_FRAC_BITS);
      if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
    end
    return neg ? clamp32(-longint'(mag)) : clamp32(longint'(mag));
  endfunction

  function automatic void material_init();
    longint g;
    g = signed_gap();
    win_lower = 32'(g);
    win_upper = 32'(clamp32(g + to_strain(signed_yield())));
    strain_committed = '0;
    strain_trial = '0;
    cur_stress = '0;
    cur_tangent = (g == 0) ? 32'(mat_modulus) : 32'sd0;
  endfunction

  function automatic void material_trial(logic signed [31:0] s);
    longint e;
    longint fy;
    longint re;
    longint d;
    logic   plastic;
    logic   slack;
    e = longint'(s);
    strain_trial = s;
    if (mat_tension) begin
      plastic = e > win_upper;
      slack = e < win_lower;
    end else begin
      plastic = e < win_upper;
      slack = e > win_lower;
    end
    if (plastic) begin
      fy = signed_yield();
      re = longint'((64'(mat_ratio) * 64'(mat_modulus)) >> RATIO_FRAC_BITS);
      d = e - signed_gap() - to_strain(fy);
      cur_stress = 32'(clamp32(fy + scale_mul(d, re)));
      cur_tangent = 32'(re);
    end else if (slack) begin
      cur_stress = '0;
      cur_tangent = '0;
    end else begin
      d = e - longint'(win_lower);
      cur_stress = 32'(scale_mul(d, 64'(mat_modulus)));
      cur_tangent = 32'(mat_modulus);
    end
  endfunction

  function automatic void material_commit();
    longint e;
    longint g;
    longint gm;
    longint rg;
    longint num;
    longint den;
    longint q;
    logic   flowed;
    logic   reloaded;
    e = longint'(strain_trial);
    g = signed_gap();
    if (mat_tension) begin
      flowed = e > win_upper;
      reloaded = (e < win_lower) && (g < e);
    end else begin
      flowed = e < win_upper;
      reloaded = (win_lower < e) && (e < g);
    end
    if (flowed) begin
      win_upper = strain_trial;
      win_lower = 32'(clamp32(e - to_strain(longint'(cur_stress))));
    end else if (reloaded) begin
      gm = (g < 0) ? -g : g;
      rg = (gm * longint'(mat_ratio)) >>> RATIO_FRAC_BITS;
      if (g < 0) rg = -rg;
      num = e - rg;
      den = (64'sd1 <<< RATIO_FRAC_BITS) - longint'(mat_ratio);
      q = (num * (64'sd1 <<< RATIO_FRAC_BITS)) / den;
      win_upper = 32'(clamp32(to_strain(signed_yield()) + q));
      win_lower = strain_trial;
    end
    strain_committed = strain_trial;
  endfunction

  function automatic gap_result_t material_step(epg_op_t op, logic signed [31:0] s);
    gap_result_t r;
    case (op)
      OP_TRIAL:  material_trial(s);
      OP_COMMIT: material_commit();
      OP_REVERT: strain_trial = strain_committed;
      default:   material_init();
    endcase
    r.stress = cur_stress;
    r.tangent = cur_tangent;
    return r;
  endfunction

  function automatic script_row_t word_row(epg_op_t op, logic signed [31:0] strain);
    script_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.op = op;
    r.value = strain;
    return r;
  endfunction

  function automatic script_row_t known_row(epg_op_t op, logic signed [31:0] strain,
                                            logic signed [31:0] stress,
                                            logic signed [31:0] tangent);
    script_row_t r;
    r = word_row(op, strain);
    r.known = 1'b1;
    r.result.stress = stress;
    r.result.tangent = tangent;
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [2:0] index, logic [30:0] value);
    script_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_index = index;
    r.value = 32'(value);
    return r;
  endfunction

  task automatic put_word(epg_op_t op, logic signed [31:0] strain, logic known,
                          gap_result_t known_result);
    int gap_len;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid = 1'b0;
      gap_len = $urandom_range(1, 15);
      repeat (gap_len) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.op = op;
    in_chan.strain_in = strain;
    use_typed = known;
    typed_result = known_result;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [30:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain_results();
    in_chan.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout", $time);
    $display("elastic_plastic_gap_material verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int burst;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_chan.ready = 1'b0;
        burst = $urandom_range(1, 15);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_chan.ready = 1'b1;
        burst = $urandom_range(1, 30);
        repeat (burst - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    gap_result_t want;
    if (!rst_n) begin
      mat_modulus = MOD_RESET;
      mat_yield = FY_RESET;
      mat_gap = GAP_RESET;
      mat_ratio = RATIO_RESET;
      mat_tension = TENS_RESET;
      material_init();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODULUS: mat_modulus = cfg_wdata;
          CFG_YIELD:   mat_yield = cfg_wdata;
          CFG_GAP:     mat_gap = cfg_wdata;
          CFG_RATIO:   mat_ratio = cfg_wdata[15:0];
          CFG_MODE:    mat_tension = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        want = material_step(epg_op_t'(in_chan.op), in_chan.strain_in);
        expected_results.push_back(use_typed ? typed_result : want);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual stress %0d tangent %0d",
                   $time, out_chan.stress_out, out_chan.tangent_out);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_chan.stress_out !== want.stress) begin
            $display("%0t: stress expected %0d actual %0d",
                     $time, want.stress, out_chan.stress_out);
            failures++;
          end
          if (out_chan.tangent_out !== want.tangent) begin
            $display("%0t: tangent expected %0d actual %0d",
                     $time, want.tangent, out_chan.tangent_out);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    script_row_t        script[$];
    script_row_t        row;
    gap_result_t        no_result;
    longint             jitter;
    longint             target;
    longint             g;
    int                 words;
    int                 sel;
    logic signed [31:0] strain;
    logic [30:0]        mod_v;
    logic [30:0]        fy_v;
    logic [30:0]        gap_v;
    logic [15:0]        ratio_v;
    logic               mode_v;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODULUS;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.op = OP_TRIAL;
    in_chan.strain_in = '0;
    use_typed = 1'b0;
    typed_result = '0;
    no_result = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    failures = 0;

    // reset settings, tension, gap zero
    script.push_back(known_row(OP_REVERT, 32'sh7FFF_FFFF, 32'sd0, 32'(MOD_RESET)));
    script.push_back(known_row(OP_TRIAL, 32'sd0, 32'sd0, 32'(MOD_RESET)));
    script.push_back(known_row(OP_TRIAL, 32'sh8000_0000, 32'sd0, 32'sd0));
    script.push_back(word_row(OP_TRIAL, 32'sd20971));
    script.push_back(word_row(OP_TRIAL, 32'sd20972));
    script.push_back(known_row(OP_TRIAL, 32'sh7FFF_FFFF, 32'(FY_RESET), 32'sd0));
    script.push_back(known_row(OP_COMMIT, 32'sd0, 32'(FY_RESET), 32'sd0));
    script.push_back(word_row(OP_TRIAL, 32'sd20000));
    script.push_back(word_row(OP_COMMIT, 32'sd0));
    script.push_back(word_row(OP_TRIAL, 32'sd30000));
    script.push_back(known_row(OP_INIT, 32'sd0, 32'sd0, 32'(MOD_RESET)));
    // open gap with hardening: flow, then reload inside the gap window
    script.push_back(reg_row(CFG_GAP, 31'd1048576));
    script.push_back(reg_row(CFG_RATIO, 31'h8000));
    script.push_back(reg_row(CFG_SPARE, 31'h7FFF_FFFF));
    script.push_back(known_row(OP_INIT, 32'sd0, 32'sd0, 32'sd0));
    script.push_back(word_row(OP_TRIAL, 32'sd524288));
    script.push_back(word_row(OP_TRIAL, 32'sd4194304));
    script.push_back(word_row(OP_COMMIT, 32'sd0));
    script.push_back(word_row(OP_TRIAL, 32'sd2097152));
    script.push_back(word_row(OP_COMMIT, 32'sd0));
    // compression, flow and reload steps mirrored
    script.push_back(reg_row(CFG_MODE, 31'd0));
    script.push_back(known_row(OP_INIT, 32'sd0, 32'sd0, 32'sd0));
    script.push_back(word_row(OP_TRIAL, -32'sd4194304));
    script.push_back(word_row(OP_COMMIT, 32'sd0));
    script.push_back(word_row(OP_TRIAL, -32'sd2097152));
    script.push_back(word_row(OP_COMMIT, 32'sd0));
    // zero modulus, full yield
    script.push_back(reg_row(CFG_MODULUS, 31'd0));
    script.push_back(reg_row(CFG_YIELD, 31'h7FFF_FFFF));
    script.push_back(known_row(OP_INIT, 32'sd0, 32'sd0, 32'sd0));
    script.push_back(word_row(OP_TRIAL, 32'sh8000_0000));
    script.push_back(word_row(OP_TRIAL, 32'sh7FFF_FFFF));

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        write_reg(row.reg_index, row.value[30:0]);
      end else begin
        put_word(row.op, row.value, row.known, row.result);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          mod_v = 31'h7FFF_FFFF;
          fy_v = 31'h7FFF_FFFF;
          gap_v = 31'h7FFF_FFFF;
          ratio_v = 16'hFFFF;
          mode_v = 1'b0;
        end
        1: begin
          mod_v = 31'd1;
          fy_v = 31'd0;
          gap_v = 31'd0;
          ratio_v = 16'd0;
          mode_v = 1'b1;
        end
        2: begin
          mod_v = 31'd0;
          fy_v = 31'($urandom_range(0, 1 << 12));
          gap_v = 31'($urandom_range(0, 1 << 25));
          ratio_v = 16'($urandom);
          mode_v = 1'($urandom);
        end
        default: begin
          mod_v = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                              : 31'($urandom_range(1 << 16, 1 << 28));
          fy_v = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                             : 31'($urandom_range(0, 1 << 22));
          case ($urandom_range(0, 3))
            0:       gap_v = 31'd0;
            1:       gap_v = 31'($urandom);
            default: gap_v = 31'($urandom_range(1, 1 << 25));
          endcase
          ratio_v = 16'($urandom);
          mode_v = 1'($urandom);
        end
      endcase
      write_reg(CFG_MODULUS, mod_v);
      write_reg(CFG_YIELD, fy_v);
      write_reg(CFG_GAP, gap_v);
      write_reg(CFG_RATIO, 31'(ratio_v));
      write_reg(CFG_MODE, 31'(mode_v));
      write_reg(3'($urandom_range(CFG_SPARE, CFG_SPARE_LAST)), 31'($urandom));
      if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
      if (ph == HOLD_PHASE) hold_req = 1'b1;

      put_word(OP_INIT, $urandom, 1'b0, no_result);
      words = 1;
      while (words < WORDS_PER_PHASE) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          put_word(epg_op_t'($urandom_range(0, 3)), $urandom, 1'b0, no_result);
          words++;
        end else if (sel == 1) begin
          put_word(OP_INIT, $urandom, 1'b0, no_result);
          words++;
        end else begin
          jitter = longint'($signed($urandom)) >>> $urandom_range(4, 31);
          g = signed_gap();
          case ($urandom_range(0, 9))
            0:       target = longint'($signed($urandom));
            1:       target = $urandom_range(0, 1) ? I32_HI : I32_LO;
            2, 3:    target = longint'(win_upper) + jitter;
            4, 5:    target = longint'(win_lower) + jitter;
            6:       target = g + jitter;
            7:       target = g + ((longint'(win_lower) - g) * $urandom_range(1, 255)) / 256;
            8: begin
              if (jitter < 0) jitter = -jitter;
              target = mat_tension ? longint'(win_upper) + jitter + 1
                                   : longint'(win_upper) - jitter - 1;
            end
            default: target = jitter;
          endcase
          strain = 32'(clamp32(target));
          put_word(OP_TRIAL, strain, 1'b0, no_result);
          words++;
          if ($urandom_range(0, 5) == 0) begin
            put_word(OP_REVERT, $urandom, 1'b0, no_result);
            words++;
          end else if ($urandom_range(0, 3) != 0) begin
            put_word(OP_COMMIT, $urandom, 1'b0, no_result);
            words++;
          end
        end
      end
    end

    drain_results();
    if (failures == 0) begin
      $display("elastic_plastic_gap_material verification clean");
    end else begin
      $display("elastic_plastic_gap_material verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/epg_pkg.sv
src/epg_in_if.sv
src/epg_out_if.sv
src/epg_div.sv
src/epg_mul.sv
src/elastic_plastic_gap_material.sv
test/elastic_plastic_gap_material_test.sv
